// File: rtl/burst_dispatch_rr_least_loaded_assert.svh
// assertion macros for the burst dispatcher checker
// expects clk and rst in the scope where a macro is used
`ifndef BURST_DISPATCH_RR_LEAST_LOADED_ASSERT_SVH
`define BURST_DISPATCH_RR_LEAST_LOADED_ASSERT_SVH

// same-cycle implication, off during reset
`define BDRR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define BDRR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bdrr_pkg.sv
// shared types and constants for the burst dispatcher
// no dependencies
`default_nettype none

package bdrr_pkg;

  localparam int ID_W       = 16;
  localparam int LEN_W      = 16;
  localparam int WORD_W     = ID_W + LEN_W;
  localparam int PROC_W     = 3;
  localparam int STATUS_W   = 3;
  localparam int QIDX_W     = 3;
  localparam int LOAD_OUT_W = 22;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BADPROC = 3'd4;

  localparam logic REQ_SUBMIT = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  localparam logic METHOD_RR = 1'b0;
  localparam logic METHOD_LL = 1'b1;

  localparam logic [CFG_IDX_W-1:0]  CFG_METHOD   = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_ACTIVE   = 1'b1;
  localparam logic [CFG_DATA_W-1:0] ACTIVE_RESET = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic pick_rr;
    logic pick_proc;
    logic set_bad;
    logic scan_init;
    logic scan_step;
    logic commit;
    logic finish_pop;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_take;
    logic least_loaded;
    logic bad_proc;
    logic scan_done;
    logic q_empty;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/burst_dispatch_rr_least_loaded.sv
// Burst dispatcher, one FIFO and load counter per processor queue. One request
// is handled at a time and every request gives one response. After the request
// transfer the controller steps through decide, then for a least-loaded submit a
// search that compares one queue load per cycle over the active queues, then
// check, then for a take from a non-empty queue a pop step for the registered
// read of the burst ram, and then offers the response; a bad processor number
// goes from decide straight to the response.
// After the response transfer the block takes a new request on the next cycle.
// Config writes are always accepted and must only be made while idle.
// depends on bdrr_pkg, bdrr_ctrl, bdrr_dpath
`default_nettype none

module burst_dispatch_rr_least_loaded #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [bdrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bdrr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire logic                            req_type,
  input  wire logic [bdrr_pkg::ID_W-1:0]       burst_id,
  input  wire logic [bdrr_pkg::LEN_W-1:0]      burst_length,
  input  wire logic [bdrr_pkg::PROC_W-1:0]     processor_index,
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output logic      [bdrr_pkg::STATUS_W-1:0]   status,
  output logic      [bdrr_pkg::QIDX_W-1:0]     queue_index,
  output logic      [bdrr_pkg::ID_W-1:0]       out_burst_id,
  output logic      [bdrr_pkg::LEN_W-1:0]      out_burst_length,
  output logic      [bdrr_pkg::LOAD_OUT_W-1:0] queue_load_after
);

  bdrr_pkg::cmd_t  cmd;
  bdrr_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  bdrr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdrr_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .req_type         (req_type),
    .burst_id         (burst_id),
    .burst_length     (burst_length),
    .processor_index  (processor_index),
    .cmd              (cmd),
    .stat             (stat),
    .status           (status),
    .queue_index      (queue_index),
    .out_burst_id     (out_burst_id),
    .out_burst_length (out_burst_length),
    .queue_load_after (queue_load_after)
  );

endmodule

`default_nettype wire

// File: rtl/bdrr_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`default_nettype none

module bdrr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/bdrr_ctrl.sv
// sequencing state machine for the burst dispatcher
// depends on bdrr_pkg
`default_nettype none

module bdrr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  input  wire bdrr_pkg::stat_t stat,
  output bdrr_pkg::cmd_t       cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    rsp_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.is_take) begin
          if (stat.bad_proc) begin
            cmd.set_bad = 1'b1;
            state_next  = S_RESP;
          end else begin
            cmd.pick_proc = 1'b1;
            state_next    = S_CHECK;
          end
        end else if (stat.least_loaded) begin
          cmd.scan_init = 1'b1;
          state_next    = S_SCAN;
        end else begin
          cmd.pick_rr = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_CHECK;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_CHECK: begin
        cmd.commit = 1'b1;
        // a take from a non-empty queue goes through the pop state for the ram read
        if (stat.is_take && !stat.q_empty) begin
          state_next = S_POP;
        end else begin
          state_next = S_RESP;
        end
      end
      S_POP: begin
        cmd.finish_pop = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        rsp_valid = 1'b1;
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/bdrr_dpath.sv
// datapath: config registers, per-queue pointers, counts and loads, burst ram
// depends on bdrr_pkg and bdrr_ram
`default_nettype none

module bdrr_dpath #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [bdrr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [bdrr_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                                req_type,
  input  wire logic [bdrr_pkg::ID_W-1:0]           burst_id,
  input  wire logic [bdrr_pkg::LEN_W-1:0]          burst_length,
  input  wire logic [bdrr_pkg::PROC_W-1:0]         processor_index,
  input  wire bdrr_pkg::cmd_t                      cmd,
  output bdrr_pkg::stat_t                          stat,
  output logic      [bdrr_pkg::STATUS_W-1:0]       status,
  output logic      [bdrr_pkg::QIDX_W-1:0]         queue_index,
  output logic      [bdrr_pkg::ID_W-1:0]           out_burst_id,
  output logic      [bdrr_pkg::LEN_W-1:0]          out_burst_length,
  output logic      [bdrr_pkg::LOAD_OUT_W-1:0]     queue_load_after
);

  localparam int QW   = $clog2(NUM_QUEUES);
  localparam int CW   = $clog2(NUM_QUEUES + 1);
  localparam int PW   = $clog2(QUEUE_DEPTH);
  localparam int NW   = $clog2(QUEUE_DEPTH + 1);
  localparam int LW   = bdrr_pkg::LEN_W + PW;
  localparam int ADEP = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW   = $clog2(ADEP);

  localparam logic [CW-1:0]   NQ_N      = CW'(NUM_QUEUES);
  localparam logic [NW-1:0]   CNT_FULL  = NW'(QUEUE_DEPTH);
  localparam logic [PW-1:0]   PTR_LAST  = PW'(QUEUE_DEPTH - 1);
  localparam logic [AW-1:0]   DEPTH_A   = AW'(QUEUE_DEPTH);

  // config
  logic                              method;
  logic [bdrr_pkg::CFG_DATA_W-1:0]   active;

  // latched request
  logic                              req_type_r;
  logic [bdrr_pkg::ID_W-1:0]         id_r;
  logic [bdrr_pkg::LEN_W-1:0]        len_r;
  logic [bdrr_pkg::PROC_W-1:0]       proc_r;

  // per-queue state
  logic [PW-1:0] heads  [NUM_QUEUES];
  logic [PW-1:0] tails  [NUM_QUEUES];
  logic [NW-1:0] counts [NUM_QUEUES];
  logic [LW-1:0] loads  [NUM_QUEUES];
  logic [QW-1:0] rr;

  // selection
  logic [QW-1:0] q;
  logic [CW-1:0] scan;
  logic [LW-1:0] best;

  // result registers
  logic [bdrr_pkg::STATUS_W-1:0] status_r;
  logic [bdrr_pkg::QIDX_W-1:0]   qout_r;
  logic [bdrr_pkg::ID_W-1:0]     pid_r;
  logic [bdrr_pkg::LEN_W-1:0]    plen_r;
  logic [LW-1:0]                 load_r;

  logic [CW+3:0]                 act_ext;
  logic [CW-1:0]                 n;
  logic [QW+2:0]                 proc_ext;
  logic [QW+2:0]                 q_ext;
  logic [QW-1:0]                 rr_q;
  logic [CW:0]                   rr_plus;
  logic [QW-1:0]                 rr_next;
  logic [QW-1:0]                 rd_idx;
  logic [LW-1:0]                 rd_load;
  logic [NW-1:0]                 cur_count;
  logic                          q_full;
  logic [LW-1:0]                 load_sum;
  logic [LW-1:0]                 pop_len;
  logic [LW-1:0]                 load_dec;
  logic [LW+bdrr_pkg::LOAD_OUT_W-1:0] load_ext;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;
  logic                          ram_we;
  logic                          ram_re;
  logic [bdrr_pkg::WORD_W-1:0]   ram_rdata;

  // active count clamped to 1..NUM_QUEUES
  assign act_ext = {CW'(0), active};
  always_comb begin
    if (active == '0) begin
      n = CW'(1);
    end else if (act_ext > (CW + 4)'(NUM_QUEUES)) begin
      n = NQ_N;
    end else begin
      n = act_ext[CW-1:0];
    end
  end

  assign proc_ext = {QW'(0), proc_r};
  assign q_ext    = {3'b000, q};

  // round-robin pick: a pointer past a lowered count restarts at queue 0
  assign rr_q    = ((CW + 1)'(rr) < (CW + 1)'(n)) ? rr : '0;
  assign rr_plus = (CW + 1)'(rr_q) + (CW + 1)'(1);
  assign rr_next = (rr_plus >= (CW + 1)'(n)) ? '0 : rr_plus[QW-1:0];

  assign rd_idx    = cmd.scan_step ? scan[QW-1:0] : q;
  assign rd_load   = loads[rd_idx];
  assign cur_count = counts[q];
  assign q_full    = (cur_count == CNT_FULL);
  assign load_sum  = rd_load + LW'(len_r);
  assign pop_len   = LW'(ram_rdata[bdrr_pkg::LEN_W-1:0]);
  assign load_dec  = (rd_load >= pop_len) ? (rd_load - pop_len) : '0;

  assign waddr  = AW'(AW'(q) * DEPTH_A + AW'(tails[q]));
  assign raddr  = AW'(AW'(q) * DEPTH_A + AW'(heads[q]));
  assign ram_we = cmd.commit && (req_type_r == bdrr_pkg::REQ_SUBMIT) && !q_full;
  assign ram_re = cmd.commit && (req_type_r == bdrr_pkg::REQ_TAKE) && (cur_count != '0);

  assign stat.is_take      = (req_type_r == bdrr_pkg::REQ_TAKE);
  assign stat.least_loaded = (method == bdrr_pkg::METHOD_LL);
  assign stat.bad_proc     = ((CW + 3)'(proc_r) >= (CW + 3)'(n));
  assign stat.scan_done    = (scan >= n);
  assign stat.q_empty      = (cur_count == '0);

  bdrr_ram #(
    .WIDTH (bdrr_pkg::WORD_W),
    .DEPTH (ADEP)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata ({id_r, len_r}),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      method <= bdrr_pkg::METHOD_RR;
      active <= bdrr_pkg::ACTIVE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bdrr_pkg::CFG_METHOD: method <= cfg_data[0];
        bdrr_pkg::CFG_ACTIVE: active <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rr <= '0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        heads[i]  <= '0;
        tails[i]  <= '0;
        counts[i] <= '0;
        loads[i]  <= '0;
      end
    end else begin
      if (cmd.pick_rr) begin
        rr <= rr_next;
      end
      if (ram_we) begin
        tails[q]  <= (tails[q] == PTR_LAST) ? '0 : tails[q] + PW'(1);
        counts[q] <= cur_count + NW'(1);
        loads[q]  <= load_sum;
      end
      if (ram_re) begin
        heads[q]  <= (heads[q] == PTR_LAST) ? '0 : heads[q] + PW'(1);
        counts[q] <= cur_count - NW'(1);
      end
      if (cmd.finish_pop) begin
        loads[q] <= load_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      req_type_r <= req_type;
      id_r       <= burst_id;
      len_r      <= burst_length;
      proc_r     <= processor_index;
    end
    if (cmd.pick_rr) begin
      q <= rr_q;
    end
    if (cmd.pick_proc) begin
      q <= proc_ext[QW-1:0];
    end
    if (cmd.scan_init) begin
      q    <= '0;
      best <= loads[0];
      scan <= CW'(1);
    end
    // strict less-than keeps the lowest index on a tie
    if (cmd.scan_step) begin
      if (rd_load < best) begin
        q    <= scan[QW-1:0];
        best <= rd_load;
      end
      scan <= scan + CW'(1);
    end
    if (cmd.set_bad) begin
      status_r <= bdrr_pkg::ST_BADPROC;
      qout_r   <= proc_r;
      pid_r    <= '0;
      plen_r   <= '0;
      load_r   <= '0;
    end
    if (cmd.commit) begin
      qout_r <= q_ext[bdrr_pkg::QIDX_W-1:0];
      pid_r  <= '0;
      plen_r <= '0;
      if (req_type_r == bdrr_pkg::REQ_SUBMIT) begin
        if (q_full) begin
          status_r <= bdrr_pkg::ST_FULL;
          load_r   <= rd_load;
        end else begin
          status_r <= bdrr_pkg::ST_QUEUED;
          load_r   <= load_sum;
        end
      end else begin
        status_r <= bdrr_pkg::ST_EMPTY;
        load_r   <= rd_load;
      end
    end
    if (cmd.finish_pop) begin
      status_r <= bdrr_pkg::ST_TAKEN;
      pid_r    <= ram_rdata[bdrr_pkg::WORD_W-1:bdrr_pkg::LEN_W];
      plen_r   <= ram_rdata[bdrr_pkg::LEN_W-1:0];
      load_r   <= load_dec;
    end
  end

  assign load_ext         = {(bdrr_pkg::LOAD_OUT_W)'(0), load_r};
  assign status           = status_r;
  assign queue_index      = qout_r;
  assign out_burst_id     = pid_r;
  assign out_burst_length = plen_r;
  assign queue_load_after = load_ext[bdrr_pkg::LOAD_OUT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/bdrr_checker.sv
// port-level checks for the burst dispatcher, bound to the top level
// depends on bdrr_pkg and burst_dispatch_rr_least_loaded_assert.svh
`default_nettype none

`include "burst_dispatch_rr_least_loaded_assert.svh"

module bdrr_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            req_valid,
  input wire logic                            req_ready,
  input wire logic                            rsp_valid,
  input wire logic                            rsp_ready,
  input wire logic [bdrr_pkg::STATUS_W-1:0]   status,
  input wire logic [bdrr_pkg::ID_W-1:0]       out_burst_id,
  input wire logic [bdrr_pkg::LEN_W-1:0]      out_burst_length,
  input wire logic [bdrr_pkg::LOAD_OUT_W-1:0] queue_load_after
);

  // a stalled response keeps its payload
  `BDRR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(out_burst_id) && $stable(out_burst_length) && $stable(queue_load_after), "response changed while stalled")

  // one request in flight: never ready while a response is pending
  `BDRR_ASSERT_NOW(a_one_in_flight, req_ready, !rsp_valid, "request ready while response pending")

  // only a taken burst carries id and length
  `BDRR_ASSERT_NOW(a_zero_payload, rsp_valid && (status != bdrr_pkg::ST_TAKEN), (out_burst_id == '0) && (out_burst_length == '0), "non-zero burst fields without a take")

  // a bad processor number reports no load
  `BDRR_ASSERT_NOW(a_bad_load, rsp_valid && (status == bdrr_pkg::ST_BADPROC), queue_load_after == '0, "bad processor with non-zero load")

endmodule

bind burst_dispatch_rr_least_loaded bdrr_checker u_bdrr_checker (
  .clk              (clk),
  .rst              (rst),
  .req_valid        (req_valid),
  .req_ready        (req_ready),
  .rsp_valid        (rsp_valid),
  .rsp_ready        (rsp_ready),
  .status           (status),
  .out_burst_id     (out_burst_id),
  .out_burst_length (out_burst_length),
  .queue_load_after (queue_load_after)
);

`default_nettype wire

// File: tb/tb.sv
// self-checking testbench for burst_dispatch_rr_least_loaded: per-queue fifo dispatch
// with round-robin and least-loaded selection, checked against an in-bench predictor
// depends on bdrr_pkg and the dispatcher rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NQ          = 8;
  localparam int QDEPTH      = 64;
  localparam int CYCLE_LIMIT = 250000;

  typedef struct packed {
    logic                        kind;
    logic [bdrr_pkg::ID_W-1:0]   id;
    logic [bdrr_pkg::LEN_W-1:0]  len;
    logic [bdrr_pkg::PROC_W-1:0] proc;
  } burst_req_t;

  typedef struct packed {
    logic [bdrr_pkg::STATUS_W-1:0]   status;
    logic [bdrr_pkg::QIDX_W-1:0]     qidx;
    logic [bdrr_pkg::ID_W-1:0]       id;
    logic [bdrr_pkg::LEN_W-1:0]      len;
    logic [bdrr_pkg::LOAD_OUT_W-1:0] load;
  } dispatch_rsp_t;

  typedef struct {
    bit                              is_reg;
    logic [bdrr_pkg::CFG_IDX_W-1:0]  reg_idx;
    logic [bdrr_pkg::CFG_DATA_W-1:0] reg_val;
    burst_req_t                      req;
    bit                              typed;
    dispatch_rsp_t                   want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bdrr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bdrr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_ready;
  logic req_type = bdrr_pkg::REQ_SUBMIT;
  logic [bdrr_pkg::ID_W-1:0] burst_id = '0;
  logic [bdrr_pkg::LEN_W-1:0] burst_length = '0;
  logic [bdrr_pkg::PROC_W-1:0] processor_index = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  logic [bdrr_pkg::STATUS_W-1:0] status;
  logic [bdrr_pkg::QIDX_W-1:0] queue_index;
  logic [bdrr_pkg::ID_W-1:0] out_burst_id;
  logic [bdrr_pkg::LEN_W-1:0] out_burst_length;
  logic [bdrr_pkg::LOAD_OUT_W-1:0] queue_load_after;

  burst_dispatch_rr_least_loaded #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(QDEPTH)
  ) i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_valid       (req_valid),
    .req_ready       (req_ready),
    .req_type        (req_type),
    .burst_id        (burst_id),
    .burst_length    (burst_length),
    .processor_index (processor_index),
    .rsp_valid       (rsp_valid),
    .rsp_ready       (rsp_ready),
    .status          (status),
    .queue_index     (queue_index),
    .out_burst_id    (out_burst_id),
    .out_burst_length(out_burst_length),
    .queue_load_after(queue_load_after)
  );

  // predictor state
  logic [bdrr_pkg::WORD_W-1:0]     burst_mem [NQ][QDEPTH];
  int                              q_head [NQ];
  int                              q_tail [NQ];
  int                              q_count [NQ];
  logic [bdrr_pkg::LOAD_OUT_W-1:0] q_load [NQ];
  int                              rr_next = 0;
  logic                            method_cfg = bdrr_pkg::METHOD_RR;
  logic [bdrr_pkg::CFG_DATA_W-1:0] active_cfg = bdrr_pkg::ACTIVE_RESET;

  dispatch_rsp_t pending_dispatches [$];
  plan_row_t     plan [$];
  int            mismatches = 0;
  int            cycles = 0;
  bit            calm = 1'b0;
  int            stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int active_queues(logic [bdrr_pkg::CFG_DATA_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > NQ) return NQ;
    return int'(setting);
  endfunction

  function automatic dispatch_rsp_t dispatch_predict(burst_req_t r);
    dispatch_rsp_t res;
    int n;
    int q;
    n = active_queues(active_cfg);
    res = '0;
    if (r.kind == bdrr_pkg::REQ_SUBMIT) begin
      if (method_cfg == bdrr_pkg::METHOD_RR) begin
        q = (rr_next < n) ? rr_next : 0;
        rr_next = (q + 1 >= n) ? 0 : q + 1;
      end else begin
        q = 0;
        for (int i = 1; i < n; i++)
          if (q_load[i] < q_load[q]) q = i;
      end
      res.qidx = (bdrr_pkg::QIDX_W)'(q);
      if (q_count[q] >= QDEPTH) begin
        res.status = bdrr_pkg::ST_FULL;
      end else begin
        burst_mem[q][q_tail[q]] = {r.id, r.len};
        q_tail[q] = (q_tail[q] + 1 >= QDEPTH) ? 0 : q_tail[q] + 1;
        q_count[q]++;
        q_load[q] = q_load[q] + r.len;
        res.status = bdrr_pkg::ST_QUEUED;
      end
      res.load = q_load[q];
    end else if (int'(r.proc) >= n) begin
      res.status = bdrr_pkg::ST_BADPROC;
      res.qidx = r.proc;
    end else begin
      q = int'(r.proc);
      res.qidx = r.proc;
      if (q_count[q] == 0) begin
        res.status = bdrr_pkg::ST_EMPTY;
      end else begin
        {res.id, res.len} = burst_mem[q][q_head[q]];
        q_head[q] = (q_head[q] + 1 >= QDEPTH) ? 0 : q_head[q] + 1;
        q_count[q]--;
        q_load[q] = (q_load[q] >= res.len) ? q_load[q] - res.len : '0;
        res.status = bdrr_pkg::ST_TAKEN;
      end
      res.load = q_load[q];
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("tb: cycle %0d %s mismatch, got %0h want %0h", cycles, what, got, want);
  endtask

  function automatic void req_row(logic kind, logic [bdrr_pkg::ID_W-1:0] id,
                                  logic [bdrr_pkg::LEN_W-1:0] len,
                                  logic [bdrr_pkg::PROC_W-1:0] proc);
    plan_row_t row;
    row = '{default: '0};
    row.req = {kind, id, len, proc};
    plan.push_back(row);
  endfunction

  function automatic void expect_row(logic [bdrr_pkg::STATUS_W-1:0] st,
                                     logic [bdrr_pkg::QIDX_W-1:0] q,
                                     logic [bdrr_pkg::ID_W-1:0] id,
                                     logic [bdrr_pkg::LEN_W-1:0] len,
                                     logic [bdrr_pkg::LOAD_OUT_W-1:0] load);
    plan[plan.size()-1].typed = 1'b1;
    plan[plan.size()-1].want = {st, q, id, len, load};
  endfunction

  function automatic void reg_row(logic [bdrr_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bdrr_pkg::CFG_DATA_W-1:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    plan.push_back(row);
  endfunction

  task automatic idle_sender(int n);
    req_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) idle_sender($urandom_range(1, 3));
  endtask

  task automatic wait_drained();
    while (pending_dispatches.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // dropping cfg_valid after each write keeps it to a single update per step
  task automatic write_reg(logic [bdrr_pkg::CFG_IDX_W-1:0] idx,
                           logic [bdrr_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bdrr_pkg::CFG_METHOD) method_cfg = val[0];
    else active_cfg = val;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_request(burst_req_t r, bit typed, dispatch_rsp_t want);
    dispatch_rsp_t predicted;
    req_valid <= 1'b1;
    req_type <= r.kind;
    burst_id <= r.id;
    burst_length <= r.len;
    processor_index <= r.proc;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = dispatch_predict(r);
    pending_dispatches.push_back(typed ? want : predicted);
  endtask

  task automatic run_phase(logic method, logic [bdrr_pkg::CFG_DATA_W-1:0] active,
                           int submit_pct, int count);
    burst_req_t r;
    dispatch_rsp_t no_want;
    int n;
    no_want = '0;
    idle_sender(1);
    wait_drained();
    // only bit 0 of the method register matters, the rest is noise
    write_reg(bdrr_pkg::CFG_METHOD, {3'($urandom_range(0, 7)), method});
    write_reg(bdrr_pkg::CFG_ACTIVE, active);
    n = active_queues(active);
    for (int k = 0; k < count; k++) begin
      r.kind = ($urandom_range(1, 100) <= submit_pct) ? bdrr_pkg::REQ_SUBMIT
                                                      : bdrr_pkg::REQ_TAKE;
      r.id = 16'($urandom);
      case ($urandom_range(0, 9))
        0: r.len = '0;
        1: r.len = '1;
        2: r.len = 16'd1;
        default: r.len = 16'($urandom);
      endcase
      r.proc = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(0, n - 1))
                                            : 3'($urandom_range(0, 7));
      push_request(r, 1'b0, no_want);
      maybe_gap();
    end
  endtask

  // response side: check each transfer, then stall in short random bursts
  always @(posedge clk) begin
    dispatch_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_dispatches.size() == 0) begin
        flag_mismatch("unexpected response", status, 0);
      end else begin
        want = pending_dispatches.pop_front();
        if (status !== want.status) flag_mismatch("status", status, want.status);
        if (queue_index !== want.qidx) flag_mismatch("queue_index", queue_index, want.qidx);
        if (out_burst_id !== want.id) flag_mismatch("out_burst_id", out_burst_id, want.id);
        if (out_burst_length !== want.len)
          flag_mismatch("out_burst_length", out_burst_length, want.len);
        if (queue_load_after !== want.load)
          flag_mismatch("queue_load_after", queue_load_after, want.load);
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  initial begin
    for (int i = 0; i < NQ; i++) begin
      q_head[i] = 0;
      q_tail[i] = 0;
      q_count[i] = 0;
      q_load[i] = '0;
    end

    // directed part, reset defaults are round-robin over eight queues
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd0);
    expect_row(bdrr_pkg::ST_EMPTY, 3'd0, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_TAKE, 16'hffff, 16'hffff, 3'd7);
    expect_row(bdrr_pkg::ST_EMPTY, 3'd7, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'hffff, 16'hffff, 3'd0);
    expect_row(bdrr_pkg::ST_QUEUED, 3'd0, 16'h0, 16'h0, 22'h00ffff);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h0000, 16'h0001, 3'd7);
    expect_row(bdrr_pkg::ST_QUEUED, 3'd1, 16'h0, 16'h0, 22'h000001);
    // zero length burst adds nothing to the load
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h1234, 16'h0000, 3'd5);
    expect_row(bdrr_pkg::ST_QUEUED, 3'd2, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd0);
    expect_row(bdrr_pkg::ST_TAKEN, 3'd0, 16'hffff, 16'hffff, 22'h0);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd2);
    expect_row(bdrr_pkg::ST_TAKEN, 3'd2, 16'h1234, 16'h0000, 22'h0);
    // pointer now sits beyond the lowered count, so the burst lands in queue 0
    reg_row(bdrr_pkg::CFG_ACTIVE, 4'd3);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'ha5a5, 16'h5a5a, 3'd2);
    expect_row(bdrr_pkg::ST_QUEUED, 3'd0, 16'h0, 16'h0, 22'h005a5a);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd3);
    expect_row(bdrr_pkg::ST_BADPROC, 3'd3, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_TAKE, 16'hffff, 16'hffff, 3'd7);
    expect_row(bdrr_pkg::ST_BADPROC, 3'd7, 16'h0, 16'h0, 22'h0);
    // a count of zero behaves as one queue
    reg_row(bdrr_pkg::CFG_ACTIVE, 4'd0);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd1);
    expect_row(bdrr_pkg::ST_BADPROC, 3'd1, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h8001, 16'h7ffe, 3'd4);
    // counts above the queue total clamp to eight
    reg_row(bdrr_pkg::CFG_ACTIVE, 4'd15);
    reg_row(bdrr_pkg::CFG_METHOD, 4'd1);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h5555, 16'h00ff, 3'd0);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'hc3c3, 16'h8000, 3'd6);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd1);
    expect_row(bdrr_pkg::ST_TAKEN, 3'd1, 16'h0000, 16'h0001, 22'h0);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd6);
    expect_row(bdrr_pkg::ST_EMPTY, 3'd6, 16'h0, 16'h0, 22'h0);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h00ff, 16'hfffe, 3'd3);
    reg_row(bdrr_pkg::CFG_METHOD, 4'd0);
    reg_row(bdrr_pkg::CFG_ACTIVE, 4'd8);
    req_row(bdrr_pkg::REQ_SUBMIT, 16'h7e7e, 16'h0100, 3'd0);
    req_row(bdrr_pkg::REQ_TAKE, 16'h0000, 16'h0000, 3'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        idle_sender(1);
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        push_request(plan[i].req, plan[i].typed, plan[i].want);
        maybe_gap();
      end
    end

    // random part, one register setting per phase
    run_phase(bdrr_pkg::METHOD_RR, 4'd8, 60, 80);
    run_phase(bdrr_pkg::METHOD_LL, 4'd8, 60, 80);
    // a single queue flooded with submits runs into the full case
    run_phase(bdrr_pkg::METHOD_RR, 4'd1, 95, 90);
    run_phase(bdrr_pkg::METHOD_RR, 4'd1, 50, 40);
    run_phase(bdrr_pkg::METHOD_LL, 4'd1, 20, 60);
    run_phase(bdrr_pkg::METHOD_RR, 4'd4, 70, 80);
    run_phase(bdrr_pkg::METHOD_LL, 4'd15, 50, 80);
    run_phase(bdrr_pkg::METHOD_RR, 4'd0, 50, 40);
    run_phase(bdrr_pkg::METHOD_LL, 4'd5, 80, 80);
    run_phase(bdrr_pkg::METHOD_RR, 4'd7, 40, 80);
    run_phase(bdrr_pkg::METHOD_LL, 4'd3, 50, 60);
    for (int p = 0; p < 2; p++)
      run_phase(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)),
                $urandom_range(10, 95), 60);
    calm = 1'b1;
    run_phase(bdrr_pkg::METHOD_RR, 4'd8, 50, 100);

    idle_sender(1);
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
